// ===== src/jsu_pkg.sv =====
// Shared types, constants and UTF-8 helpers for the JSON string unescaper.
package jsu_pkg;

    // Deepest burst of results that one input byte can cause
    localparam int unsigned Depth = 6;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } entry_t;

    // Up to four UTF-8 bytes, byte 0 goes out first
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.len      = 3'd1;
            r.bytes[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF) begin
            r.len      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF) begin
            r.len      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            r.len      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic utf8_t utf8_single(input logic [7:0] b);
        utf8_t r;
        r          = '0;
        r.len      = 3'd1;
        r.bytes[0] = b;
        return r;
    endfunction

    // Bit 4 set when the byte is a hex digit; bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] t;
        t = 8'h00;
        if (b inside {[8'h30:8'h39]}) begin
            return {1'b1, b[3:0]};
        end
        else if (b inside {[8'h61:8'h66]}) begin
            t = b - 8'h57;
            return {1'b1, t[3:0]};
        end
        else if (b inside {[8'h41:8'h46]}) begin
            t = b - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// ===== src/jsu_if.sv =====
// Valid/ready channel interfaces for string body bytes and decoded results.
interface jsu_in_if ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first;
    logic       buffer_end;

    modport source (output valid, output in_byte, output first, output buffer_end,
                    input ready);
    modport sink   (input valid, input in_byte, input first, input buffer_end,
                    output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    status_t    status;
    logic       end_of_run;

    modport source (output valid, output out_byte, output status, output end_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input end_of_run,
                    output ready);
endinterface

// ===== src/json_string_unescape_utf8.sv =====
// JSON string body unescaper with UTF-8 output: decoder and result buffer.
//
//  channel   dir  payload                         handshake
//  bytes     in   in_byte[8] first buffer_end     valid/ready
//  results   out  out_byte[8] status[2] end_run   valid/ready
//
// One request is decoded in the cycle it is accepted; its 0 to 6 results are
// loaded into a 6-entry shift buffer and leave one per cycle while the receiver
// is ready. A byte is taken every cycle while each byte yields at most one result
// and the receiver is ready; a byte that yields more holds the input (buffer drain).
// Reset clears the decoder to idle and empties the buffer.
// A stall on results holds bytes.ready low once the last buffered result waits.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    bytes,
    jsu_out_if.source results
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_TEXT,
        M_ESC,
        M_HEX,
        M_HELD,
        M_HELD_ESC,
        M_LOW_HEX
    } mode_t;

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChSpace  = 8'h20;

    mode_t       mode_reg, mode_next;
    logic [15:0] hv_reg, hv_next;
    logic [2:0]  hc_reg, hc_next;
    logic [9:0]  held_reg, held_next;

    entry_t      buf_reg [Depth];
    entry_t      buf_next [Depth];
    logic [2:0]  cnt_reg, cnt_next;

    logic        in_acc, out_acc;
    logic [7:0]  b;

    // decode intermediates
    mode_t       m;
    logic [15:0] hv, hv_sh;
    logic [2:0]  hc, hc_inc;
    logic [9:0]  held;
    logic [4:0]  dig;
    logic        idle, flush, closed, bad;
    utf8_t       mn, fl;
    logic [2:0]  n_data, new_n;
    logic [5:0][7:0] seq;

    // plain-byte and escape-byte classification
    logic        p_closed, p_bad, p_esc, p_put;
    logic        e_put, e_u, e_bad;
    logic [7:0]  e_char;

    assign b       = bytes.in_byte;
    assign in_acc  = bytes.valid && bytes.ready;
    assign out_acc = results.valid && results.ready;

    assign bytes.ready        = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && results.ready);
    assign results.valid      = (cnt_reg != 3'd0);
    assign results.out_byte   = buf_reg[0].data;
    assign results.status     = buf_reg[0].status;
    assign results.end_of_run = (cnt_reg == 3'd1);

    always_comb
    begin
        p_closed = (b == ChQuote);
        p_bad    = !p_closed && (b < ChSpace);
        p_esc    = (b == ChBslash);
        p_put    = !p_closed && !p_bad && !p_esc;

        e_put  = 1'b1;
        e_u    = 1'b0;
        e_bad  = 1'b0;
        e_char = b;
        case (b)
            ChQuote, ChBslash, ChSlash: e_char = b;
            8'h62:   e_char = 8'h08;
            8'h66:   e_char = 8'h0C;
            8'h6E:   e_char = 8'h0A;
            8'h72:   e_char = 8'h0D;
            8'h74:   e_char = 8'h09;
            8'h75:
            begin
                e_put = 1'b0;
                e_u   = 1'b1;
            end
            default:
            begin
                e_put = 1'b0;
                e_bad = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        m    = mode_reg;
        hv   = hv_reg;
        hc   = hc_reg;
        held = held_reg;
        if (bytes.first)
        begin
            m    = M_TEXT;
            hv   = '0;
            hc   = '0;
            held = '0;
        end

        mode_next = m;
        hv_next   = hv;
        hc_next   = hc;
        held_next = held;
        idle      = 1'b0;
        flush     = 1'b0;
        closed    = 1'b0;
        bad       = 1'b0;
        mn        = '0;

        dig    = hex_digit(b);
        hv_sh  = {hv[11:0], dig[3:0]};
        hc_inc = hc + 3'd1;

        case (m)
            M_TEXT, M_HELD:
            begin
                if (m == M_HELD && p_esc)
                begin
                    mode_next = M_HELD_ESC;
                end
                else
                begin
                    flush     = (m == M_HELD);
                    mode_next = p_esc ? M_ESC : M_TEXT;
                    closed    = p_closed;
                    bad       = p_bad;
                    if (p_put)
                        mn = utf8_single(b);
                end
            end
            M_ESC, M_HELD_ESC:
            begin
                flush     = (m == M_HELD_ESC) && !e_u;
                mode_next = !e_u ? M_TEXT : (m == M_HELD_ESC) ? M_LOW_HEX : M_HEX;
                bad       = e_bad;
                if (e_u)
                begin
                    hv_next = '0;
                    hc_next = '0;
                end
                if (e_put)
                    mn = utf8_single(e_char);
            end
            M_HEX, M_LOW_HEX:
            begin
                if (!dig[4])
                begin
                    bad = 1'b1;
                end
                else
                begin
                    hv_next = hv_sh;
                    hc_next = hc_inc;
                    if (hc_inc >= 3'd4)
                    begin
                        if (m == M_LOW_HEX && hv_sh[15:10] == 6'b110111)
                        begin
                            // join the held high half with this low half
                            mn        = utf8_encode(21'h10000 + 21'({held, hv_sh[9:0]}));
                            mode_next = M_TEXT;
                        end
                        else
                        begin
                            flush = (m == M_LOW_HEX);
                            if (hv_sh[15:10] == 6'b110110)
                            begin
                                held_next = hv_sh[9:0];
                                mode_next = M_HELD;
                            end
                            else
                            begin
                                mn        = utf8_encode({5'd0, hv_sh});
                                mode_next = M_TEXT;
                            end
                        end
                    end
                end
            end
            default:
            begin
                // idle byte: drop it
                idle      = 1'b1;
                mode_next = M_IDLE;
            end
        endcase

        if (!idle && !closed && !bad && bytes.buffer_end)
            bad = 1'b1;

        if (bad || closed)
        begin
            mode_next = M_IDLE;
            hv_next   = '0;
            hc_next   = '0;
            held_next = '0;
        end
    end

    // assemble the burst of results
    always_comb
    begin
        fl     = utf8_encode({5'd0, 6'b110110, held});
        n_data = (flush ? 3'd3 : 3'd0) + mn.len;
        if (flush)
            seq = {mn.bytes[2], mn.bytes[1], mn.bytes[0],
                   fl.bytes[2], fl.bytes[1], fl.bytes[0]};
        else
            seq = {16'h0000, mn.bytes};

        if (bad)
            new_n = 3'd1;
        else
            new_n = n_data + {2'b00, closed};

        for (int k = 0; k < Depth; k++)
        begin
            buf_next[k] = '{data: seq[k], status: ST_DATA};
            if (bad)
                buf_next[k] = '{data: 8'h00, status: ST_ERROR};
            else if (closed && 3'(k) == n_data)
                buf_next[k] = '{data: 8'h00, status: ST_DONE};
        end

        cnt_next = cnt_reg;
        if (in_acc && new_n != 3'd0)
            cnt_next = new_n;
        else if (out_acc)
            cnt_next = cnt_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            hv_reg   <= '0;
            hc_reg   <= '0;
            held_reg <= '0;
            cnt_reg  <= '0;
            for (int k = 0; k < Depth; k++)
                buf_reg[k] <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                mode_reg <= mode_next;
                hv_reg   <= hv_next;
                hc_reg   <= hc_next;
                held_reg <= held_next;
            end
            cnt_reg <= cnt_next;
            if (in_acc && new_n != 3'd0)
            begin
                for (int k = 0; k < Depth; k++)
                    buf_reg[k] <= buf_next[k];
            end
            else if (out_acc)
            begin
                // advance the burst by one result
                for (int k = 0; k < Depth - 1; k++)
                    buf_reg[k] <= buf_reg[k + 1];
            end
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(Depth))
        else $error("result count beyond buffer depth");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.status == ST_ERROR |-> results.end_of_run)
        else $error("error result not alone in its burst");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.status == ST_DONE |-> results.end_of_run)
        else $error("done result not last in its burst");

    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (bad || closed) |=> mode_reg == M_IDLE && hc_reg == 3'd0)
        else $error("decoder not idle after end of string");

    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> results.valid)
        else $error("input held without a waiting result");

endmodule

// ===== tb/json_string_unescape_utf8_test.sv =====
// Self-checking testbench for the JSON string unescaper: random strings, scoreboard, stalls.
module json_string_unescape_utf8_test
    import jsu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    class unescape_scoreboard;
        typedef enum logic [2:0] {
            DEC_IDLE,
            DEC_TEXT,
            DEC_ESC,
            DEC_HEX,
            DEC_HELD,
            DEC_HELD_ESC,
            DEC_LOW_HEX
        } dec_mode_t;

        typedef struct packed {
            logic [7:0] data;
            status_t    status;
            logic       last;
        } result_t;

        result_t     due[$];
        int          failures;
        dec_mode_t   mode;
        logic [15:0] hex_value;
        logic [2:0]  hex_count;
        logic [9:0]  held_high;
        logic        high_pending;
        logic [7:0]  decoded[$];
        logic        closed;
        logic        bad;

        function new();
            failures = 0;
            clear_decoder();
        endfunction

        function void clear_decoder();
            mode         = DEC_IDLE;
            hex_value    = '0;
            hex_count    = '0;
            held_high    = '0;
            high_pending = 1'b0;
        endfunction

        function void emit_code_point(logic [20:0] cp);
            if (cp < 21'h80) begin
                decoded.push_back(cp[7:0]);
            end
            else if (cp < 21'h800) begin
                decoded.push_back(8'hC0 | {3'b000, cp[10:6]});
                decoded.push_back(8'h80 | {2'b00, cp[5:0]});
            end
            else if (cp < 21'h10000) begin
                decoded.push_back(8'hE0 | {4'b0000, cp[15:12]});
                decoded.push_back(8'h80 | {2'b00, cp[11:6]});
                decoded.push_back(8'h80 | {2'b00, cp[5:0]});
            end
            else begin
                decoded.push_back(8'hF0 | {5'b00000, cp[20:18]});
                decoded.push_back(8'h80 | {2'b00, cp[17:12]});
                decoded.push_back(8'h80 | {2'b00, cp[11:6]});
                decoded.push_back(8'h80 | {2'b00, cp[5:0]});
            end
        endfunction

        // Send the held high surrogate on its own as three bytes
        function void flush_high();
            emit_code_point({11'h036, held_high});
            high_pending = 1'b0;
        endfunction

        function void take_plain(logic [7:0] b);
            mode = DEC_TEXT;
            if (b == 8'h22) begin
                closed = 1'b1;
            end
            else if (b < 8'h20) begin
                bad = 1'b1;
            end
            else if (b == 8'h5C) begin
                mode = DEC_ESC;
            end
            else begin
                decoded.push_back(b);
            end
        endfunction

        function void take_escape(logic [7:0] b, dec_mode_t hex_mode);
            mode = DEC_TEXT;
            case (b)
                8'h22, 8'h5C, 8'h2F: decoded.push_back(b);
                8'h62: decoded.push_back(8'h08);
                8'h66: decoded.push_back(8'h0C);
                8'h6E: decoded.push_back(8'h0A);
                8'h72: decoded.push_back(8'h0D);
                8'h74: decoded.push_back(8'h09);
                8'h75:
                begin
                    mode      = hex_mode;
                    hex_value = '0;
                    hex_count = '0;
                end
                default: bad = 1'b1;
            endcase
        endfunction

        function void finish_unit(logic [15:0] v);
            if (v >= 16'hD800 && v <= 16'hDBFF) begin
                held_high    = v[9:0];
                high_pending = 1'b1;
                mode         = DEC_HELD;
            end
            else begin
                emit_code_point({5'd0, v});
                mode = DEC_TEXT;
            end
        endfunction

        // Shift in one hex digit; true once the fourth has arrived
        function bit shift_digit(logic [7:0] b);
            logic [7:0] t;
            logic [3:0] d;
            t = 8'h00;
            if (b >= 8'h30 && b <= 8'h39) begin
                t = b - 8'h30;
            end
            else if (b >= 8'h61 && b <= 8'h66) begin
                t = b - 8'h57;
            end
            else if (b >= 8'h41 && b <= 8'h46) begin
                t = b - 8'h37;
            end
            else begin
                bad = 1'b1;
                return 1'b0;
            end
            d         = t[3:0];
            hex_value = {hex_value[11:0], d};
            hex_count = hex_count + 3'd1;
            return hex_count >= 3'd4;
        endfunction

        function void note_request(logic [7:0] b, logic f, logic e);
            result_t r;
            decoded.delete();
            closed = 1'b0;
            bad    = 1'b0;
            if (f) begin
                clear_decoder();
                mode = DEC_TEXT;
            end
            else if (mode == DEC_IDLE) begin
                return;
            end

            case (mode)
                DEC_TEXT: take_plain(b);
                DEC_ESC: take_escape(b, DEC_HEX);
                DEC_HEX:
                begin
                    if (shift_digit(b)) finish_unit(hex_value);
                end
                DEC_HELD:
                begin
                    if (b == 8'h5C) begin
                        mode = DEC_HELD_ESC;
                    end
                    else begin
                        flush_high();
                        take_plain(b);
                    end
                end
                DEC_HELD_ESC:
                begin
                    if (b == 8'h75) begin
                        take_escape(b, DEC_LOW_HEX);
                    end
                    else begin
                        flush_high();
                        take_escape(b, DEC_HEX);
                    end
                end
                default:
                begin
                    if (shift_digit(b)) begin
                        if (hex_value >= 16'hDC00 && hex_value <= 16'hDFFF) begin
                            emit_code_point(21'h10000 + {1'b0, held_high, hex_value[9:0]});
                            high_pending = 1'b0;
                            mode         = DEC_TEXT;
                        end
                        else begin
                            flush_high();
                            finish_unit(hex_value);
                        end
                    end
                end
            endcase

            if (!closed && !bad && e) bad = 1'b1;

            // A malformed request gives one error result and drops its data
            if (bad) begin
                clear_decoder();
                r.data   = 8'h00;
                r.status = ST_ERROR;
                r.last   = 1'b1;
                due.push_back(r);
                return;
            end

            foreach (decoded[i]) begin
                r.data   = decoded[i];
                r.status = ST_DATA;
                r.last   = (i == decoded.size() - 1) && !closed;
                due.push_back(r);
            end
            if (closed) begin
                clear_decoder();
                r.data   = 8'h00;
                r.status = ST_DONE;
                r.last   = 1'b1;
                due.push_back(r);
            end
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= 10) $display("mismatch: %s", what);
        endfunction

        function void check_result(logic [7:0] data, status_t status, logic last);
            result_t want;
            if (due.size() == 0) begin
                note_failure($sformatf("unexpected result data %02h status %0d last %0b",
                                       data, status, last));
                return;
            end
            want = due.pop_front();
            if (data !== want.data || status !== want.status || last !== want.last) begin
                note_failure($sformatf(
                    "expected data %02h status %0d last %0b, got data %02h status %0d last %0b",
                    want.data, want.status, want.last, data, status, last));
            end
        endfunction
    endclass

    typedef struct {
        logic [7:0] b;
        logic       f;
        logic       e;
        bit         live;
    } req_t;

    logic clk = 1'b0;
    logic rst_n;

    jsu_in_if  bytes_if ();
    jsu_out_if results_if ();

    json_string_unescape_utf8 DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .results (results_if)
    );

    unescape_scoreboard sb;
    req_t line_q[$];
    bit   opening;
    int   body_count = 0;
    bit   calm = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function void add_byte(logic [7:0] b, logic e = 1'b0);
        req_t r;
        r.b     = b;
        r.f     = opening;
        r.e     = e;
        r.live  = 1'b1;
        opening = 1'b0;
        line_q.push_back(r);
    endfunction

    // Byte offered while the decoder is idle: dropped by the block
    function void add_noise(logic [7:0] b);
        req_t r;
        r.b    = b;
        r.f    = 1'b0;
        r.e    = 1'($urandom_range(1));
        r.live = 1'b0;
        line_q.push_back(r);
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function void add_unit(logic [15:0] v);
        add_byte(8'h5C);
        add_byte(8'h75);
        for (int k = 3; k >= 0; k--) add_byte(hex_char(v[k*4 +: 4]));
    endfunction

    function logic [7:0] random_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(255, 32)); while (b == 8'h22 || b == 8'h5C);
        return b;
    endfunction

    function logic [7:0] escape_letter(int k);
        case (k)
            0: return 8'h22;
            1: return 8'h5C;
            2: return 8'h2F;
            3: return 8'h62;
            4: return 8'h66;
            5: return 8'h6E;
            6: return 8'h72;
            default: return 8'h74;
        endcase
    endfunction

    function logic [15:0] random_high();
        return 16'hD800 | 16'($urandom_range(16'h3FF));
    endfunction

    function logic [15:0] random_low();
        return 16'hDC00 | 16'($urandom_range(16'h3FF));
    endfunction

    // Code unit outside the surrogate range, spread over the UTF-8 lengths
    function logic [15:0] random_bmp();
        case ($urandom_range(2))
            0: return 16'($urandom_range(16'h7F));
            1: return 16'($urandom_range(16'h7FF, 16'h80));
            default:
            begin
                if ($urandom_range(1)) return 16'($urandom_range(16'hD7FF, 16'h800));
                return 16'($urandom_range(16'hFFFF, 16'hE000));
            end
        endcase
    endfunction

    function void add_token();
        case ($urandom_range(12))
            0, 1, 2: add_byte(random_plain());
            3:
            begin
                add_byte(8'h5C);
                add_byte(escape_letter($urandom_range(7)));
            end
            4, 5: add_unit(random_bmp());
            6: add_unit(random_low());
            7, 8:
            begin
                add_unit(random_high());
                add_unit(random_low());
            end
            9:
            begin
                add_unit(random_high());
                add_byte(random_plain());
            end
            10:
            begin
                add_unit(random_high());
                add_byte(8'h5C);
                add_byte(escape_letter($urandom_range(7)));
            end
            11:
            begin
                add_unit(random_high());
                add_unit($urandom_range(1) ? random_high() : random_bmp());
            end
            default: add_unit(random_high());
        endcase
    endfunction

    task automatic send_req(req_t r);
        while (!calm && $urandom_range(99) < 27) begin
            bytes_if.valid <= 1'b0;
            @(posedge clk);
        end
        bytes_if.valid      <= 1'b1;
        bytes_if.in_byte    <= r.b;
        bytes_if.first      <= r.f;
        bytes_if.buffer_end <= r.e;
        do @(posedge clk); while (!bytes_if.ready);
        sb.note_request(r.b, r.f, r.e);
        if (r.live) body_count++;
        calm = (body_count >= 200 && body_count < 290);
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_req(line_q[i]);
        line_q.delete();
    endtask

    task automatic send_random_string();
        int         ending;
        logic [7:0] c;
        opening = 1'b1;
        repeat ($urandom_range(6)) add_token();
        ending = $urandom_range(99);
        if (ending < 70) begin
            add_byte(8'h22, $urandom_range(3) == 0);
        end
        else if (ending < 76) begin
            // run out of input, possibly in the middle of an escape
            add_byte($urandom_range(1) ? random_plain() : 8'h5C, 1'b1);
        end
        else if (ending < 84) begin
            add_byte(8'($urandom_range(31)), 1'($urandom_range(1)));
        end
        else if (ending < 90) begin
            add_byte(8'h5C);
            do c = 8'($urandom_range(255));
            while (c inside {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h75});
            add_byte(c);
        end
        else if (ending < 96) begin
            // broken digit, sometimes in the low half after a held high surrogate
            if ($urandom_range(1)) add_unit(random_high());
            add_byte(8'h5C);
            add_byte(8'h75);
            repeat ($urandom_range(3)) add_byte(hex_char(4'($urandom_range(15))));
            do c = 8'($urandom_range(255));
            while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
            add_byte(c);
        end
        // otherwise leave the string open: the next one restarts the decoder
        if (ending < 96 && $urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) add_noise(8'($urandom_range(255)));
        end
        send_line();
    endtask

    initial
    begin
        sb                  = new();
        rst_n               = 1'b0;
        bytes_if.valid      = 1'b0;
        bytes_if.in_byte    = 8'h00;
        bytes_if.first      = 1'b0;
        bytes_if.buffer_end = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        add_noise(8'h41);
        opening = 1'b1;
        add_byte(8'h20);
        add_byte(8'hFF);
        add_byte(8'h22);
        opening = 1'b1;
        add_byte(8'h5C);
        add_byte(8'h62);
        add_byte(8'h5C);
        add_byte(8'h74);
        add_unit(16'hD83D);
        add_unit(16'hDE00);
        add_byte(8'h22, 1'b1);
        opening = 1'b1;
        add_byte(8'h1F);
        opening = 1'b1;
        add_byte(8'h78, 1'b1);
        add_noise(8'h00);
        opening = 1'b1;
        add_byte(8'h5C);
        add_byte(8'h71);
        send_line();

        while (body_count < 400) send_random_string();
        bytes_if.valid <= 1'b0;

        while (sb.due.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.failures == 0 && sb.due.size() == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver: random stalls, a calm stretch and one long hold-off to fill the buffer
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left        = 0;
        hold_done        = 1'b0;
        results_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                results_if.ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && body_count >= 120) begin
                hold_done        = 1'b1;
                hold_left        = 79;
                results_if.ready <= 1'b0;
            end
            else begin
                results_if.ready <= calm || ($urandom_range(99) >= 27);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready) begin
            sb.check_result(results_if.out_byte, results_if.status, results_if.end_of_run);
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
